// ===== src/q15alu_pkg.sv =====
package q15alu_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_ADD_SAT = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_MUL = 3'd3;
  localparam logic [2:0] MODE_DIV = 3'd4;
  localparam logic [2:0] MODE_ACC = 3'd5;

  // Q15 format constants.
  localparam int FRAC_BITS = 15;
  localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN = -16'sh8000;
  localparam logic signed [31:0] ROUND_HALF = 32'sd1 <<< (FRAC_BITS - 1);

  // Width of the dividend magnitude, and with it the number of divider cells.
  localparam int DVD_W = 31;
  localparam int CELLS = DVD_W;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] operand_a;
    logic signed [15:0] operand_b;
    logic signed [31:0] accumulator_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
  } out_t;

  // Everything that travels down the cell chain with one operation.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] simple;
    logic signed [31:0] product;
    logic               dbz;
    logic               neg;
    logic [DVD_W-1:0]   dvd;
    logic [15:0]        dsr;
    logic [15:0]        rem;
    logic [15:0]        quo;
  } stage_t;

endpackage

// ===== src/q15alu_prep.sv =====
module q15alu_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  q15alu_pkg::in_t     data_in,
  output logic                valid,
  output q15alu_pkg::stage_t  stage
);

  logic signed [15:0] a;
  logic signed [15:0] b;
  logic signed [16:0] sum17;
  logic signed [16:0] diff17;
  logic signed [31:0] a32;
  logic signed [31:0] a_sh;
  logic signed [16:0] b17;
  logic signed [16:0] half;
  logic signed [31:0] t;
  logic [31:0]        t_abs;
  logic [15:0]        b_abs;
  logic signed [31:0] simple_next;
  q15alu_pkg::stage_t stage_next;

  assign a = data_in.operand_a;
  assign b = data_in.operand_b;

  // Adds, subtract and accumulate are finished here.
  always_comb begin
    sum17  = 17'(a) + 17'(b);
    diff17 = 17'(a) - 17'(b);
    a32    = 32'(a);
    case (data_in.mode)
      q15alu_pkg::MODE_ADD: begin
        simple_next = 32'($signed(sum17[15:0]));
      end
      q15alu_pkg::MODE_ADD_SAT: begin
        if (sum17[16] != sum17[15]) begin
          simple_next = sum17[16] ? 32'(q15alu_pkg::Q15_MIN) : 32'(q15alu_pkg::Q15_MAX);
        end else begin
          simple_next = 32'($signed(sum17[15:0]));
        end
      end
      q15alu_pkg::MODE_SUB: begin
        simple_next = 32'($signed(diff17[15:0]));
      end
      q15alu_pkg::MODE_ACC: begin
        simple_next = data_in.accumulator_in + a32;
      end
      default: begin
        simple_next = '0;
      end
    endcase
  end

  // Divide setup: rounded dividend, then magnitudes and quotient sign.
  always_comb begin
    a_sh  = a32 <<< q15alu_pkg::FRAC_BITS;
    b17   = 17'(b) + 17'({16'd0, b[15] & b[0]});
    half  = b17 >>> 1;
    if (a[15] == b[15]) begin
      t = a_sh + 32'(half);
    end else begin
      t = a_sh - 32'(half);
    end
    t_abs = t[31] ? 32'(-t) : 32'(t);
    b_abs = b[15] ? 16'(-b) : 16'(b);
  end

  always_comb begin
    stage_next.mode    = data_in.mode;
    stage_next.simple  = simple_next;
    stage_next.product = 32'(a) * 32'(b);
    stage_next.dbz     = (data_in.mode == q15alu_pkg::MODE_DIV) && (b == 16'sd0);
    stage_next.neg     = t[31] ^ b[15];
    stage_next.dvd     = t_abs[q15alu_pkg::DVD_W-1:0];
    stage_next.dsr     = b_abs;
    stage_next.rem     = '0;
    stage_next.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage <= stage_next;
  end

endmodule

// ===== src/q15alu_cell.sv =====
module q15alu_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  q15alu_pkg::stage_t  stage_in,
  output logic                valid,
  output q15alu_pkg::stage_t  stage
);

  logic [16:0]        rem_sh;
  logic [17:0]        diff;
  q15alu_pkg::stage_t stage_next;

  // One restoring division step: bring down a dividend bit, try the subtract.
  always_comb begin
    rem_sh     = {stage_in.rem, stage_in.dvd[q15alu_pkg::DVD_W-1]};
    diff       = {1'b0, rem_sh} - {2'b00, stage_in.dsr};
    stage_next = stage_in;
    stage_next.dvd = {stage_in.dvd[q15alu_pkg::DVD_W-2:0], 1'b0};
    if (!diff[17]) begin
      stage_next.rem = diff[15:0];
      stage_next.quo = {stage_in.quo[14:0], 1'b1};
    end else begin
      stage_next.rem = rem_sh[15:0];
      stage_next.quo = {stage_in.quo[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage <= stage_next;
  end

endmodule

// ===== src/q15alu_final.sv =====
module q15alu_final (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  q15alu_pkg::stage_t  stage_in,
  output logic                valid,
  output q15alu_pkg::out_t    data
);

  logic signed [31:0] p_round;
  logic signed [16:0] p_shift;
  logic signed [15:0] p_sat;
  logic [15:0]        q_signed;
  q15alu_pkg::out_t   data_next;

  // Multiply: round half up, drop the fraction bits, saturate.
  always_comb begin
    p_round = stage_in.product + q15alu_pkg::ROUND_HALF;
    p_shift = 17'(p_round >>> q15alu_pkg::FRAC_BITS);
    if (p_shift > 17'(q15alu_pkg::Q15_MAX)) begin
      p_sat = q15alu_pkg::Q15_MAX;
    end else if (p_shift < 17'(q15alu_pkg::Q15_MIN)) begin
      p_sat = q15alu_pkg::Q15_MIN;
    end else begin
      p_sat = p_shift[15:0];
    end
    q_signed = stage_in.neg ? 16'(-stage_in.quo) : stage_in.quo;
  end

  // Pick the result for the operation.
  always_comb begin
    data_next.divide_by_zero = stage_in.dbz;
    case (stage_in.mode)
      q15alu_pkg::MODE_MUL: begin
        data_next.result = 32'(p_sat);
      end
      q15alu_pkg::MODE_DIV: begin
        data_next.result = stage_in.dbz ? 32'sd0 : 32'($signed(q_signed));
      end
      default: begin
        data_next.result = stage_in.simple;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== src/q15_fixed_point_alu.sv =====
// Q15 arithmetic unit: wrapping add, saturating add, subtract, rounded and
// saturated multiply, rounded divide and Q17.15 accumulate. One operation is
// taken in every clock cycle; busy never rises, since the result path cannot
// be stalled and every operation walks the same fixed-length pipeline. Each
// result appears for one cycle, with strobe high, after it has passed through
// one setup stage, 31 restoring divider cells (one quotient bit per cell, the
// other operations riding along), and one output stage. Results leave in the
// order that operations entered, and the receiver must take each transfer
// in the cycle that strobe marks it.
module q15_fixed_point_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  q15alu_pkg::in_t   operands,
  output logic              strobe,
  output q15alu_pkg::out_t  answer
);

  logic               chain_valid [q15alu_pkg::CELLS+1];
  q15alu_pkg::stage_t chain_stage [q15alu_pkg::CELLS+1];

  assign busy = 1'b0;

  // Operand setup and the non-divide operations.
  q15alu_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .valid_in (start),
    .data_in  (operands),
    .valid    (chain_valid[0]),
    .stage    (chain_stage[0])
  );

  // Row of divider cells, one quotient bit each.
  for (genvar i = 0; i < q15alu_pkg::CELLS; i++) begin : g_cell
    q15alu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (chain_valid[i]),
      .stage_in (chain_stage[i]),
      .valid    (chain_valid[i+1]),
      .stage    (chain_stage[i+1])
    );
  end

  // Multiply rounding, quotient sign and result selection.
  q15alu_final u_final (
    .clk      (clk),
    .rst      (rst),
    .valid_in (chain_valid[q15alu_pkg::CELLS]),
    .stage_in (chain_stage[q15alu_pkg::CELLS]),
    .valid    (strobe),
    .data     (answer)
  );

endmodule
